[src/assert_macros.svh]
// Assertion helpers shared by the RTL; clk and rst must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside of reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a clock edge outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

[src/ipv6tp_pkg.sv]
package ipv6tp_pkg;

  localparam int GROUPS      = 8;
  localparam int GROUP_IDX_W = 3;
  localparam int COUNT_W     = 4;

  typedef logic [15:0]        group_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HEAD       = 3'd1;
  localparam logic [2:0] PH_HEAD_COLON = 3'd2;
  localparam logic [2:0] PH_TAIL       = 3'd3;
  localparam logic [2:0] PH_TAIL_COLON = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  // Bit 4 set means not a hex digit; bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

[src/ipv6_text_address_parser.sv]
// Channel  Dir  Fields (tdata / tuser, lowest bit first)
// s_*      in   tdata: ch[7:0]                         tuser: first
// m_*      out  tdata: addr_high, addr_low, stop_char   tuser: had_double_colon,
//                                                              too_many_groups
//
// One character per cycle unless stalled; any result shows on m_* the next cycle.
// The result register frees s_tready while a waiting result is being taken.
// s_tready drops only while a result is held and m_tready is low.
// Reset clears the parse state to idle and empties the result register.
// Text before a character marked first is dropped.

`include "assert_macros.svh"

module ipv6_text_address_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // ch[7:0]
  input  logic         s_tuser,   // first
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // addr_high[63:0], addr_low[127:64], stop_char[135:128]
  output logic [1:0]   m_tuser    // had_double_colon[0], too_many_groups[1]
);

  ipv6tp_pkg::group_t head_groups [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::group_t tail_groups [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::count_t head_count;
  ipv6tp_pkg::count_t tail_count;
  ipv6tp_pkg::group_t group_accum;
  logic               digit_seen;
  logic [2:0]         parse_phase;
  logic               overflow_seen;

  ipv6tp_pkg::group_t head_groups_next [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::group_t tail_groups_next [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::count_t head_count_next;
  ipv6tp_pkg::count_t tail_count_next;
  ipv6tp_pkg::group_t group_accum_next;
  logic               digit_seen_next;
  logic [2:0]         parse_phase_next;
  logic               overflow_seen_next;

  logic               emit;
  logic               emit_dc;
  logic [127:0]       addr_next;

  logic               out_valid;
  logic [135:0]       out_data;
  logic [1:0]         out_user;

  logic               in_fire;

  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    logic       go;
    logic       skip;
    logic       in_tail;
    logic [4:0] hv;
    head_groups_next   = head_groups;
    tail_groups_next   = tail_groups;
    head_count_next    = head_count;
    tail_count_next    = tail_count;
    group_accum_next   = group_accum;
    digit_seen_next    = digit_seen;
    parse_phase_next   = parse_phase;
    overflow_seen_next = overflow_seen;
    emit    = 1'b0;
    emit_dc = 1'b0;
    go      = 1'b0;
    skip    = 1'b0;
    in_tail = 1'b0;
    hv      = ipv6tp_pkg::hex_digit(s_tdata);

    if (in_fire) begin
      if (s_tuser) begin
        // restart: drop any address in progress
        for (int i = 0; i < ipv6tp_pkg::GROUPS; i++) begin
          head_groups_next[i] = '0;
          tail_groups_next[i] = '0;
        end
        head_count_next    = '0;
        tail_count_next    = '0;
        group_accum_next   = '0;
        digit_seen_next    = 1'b0;
        overflow_seen_next = 1'b0;
        parse_phase_next   = ipv6tp_pkg::PH_HEAD;
        go = (s_tdata != ipv6tp_pkg::CH_LBRACK);
      end else begin
        go = (parse_phase == ipv6tp_pkg::PH_HEAD) ||
             (parse_phase == ipv6tp_pkg::PH_HEAD_COLON) ||
             (parse_phase == ipv6tp_pkg::PH_TAIL) ||
             (parse_phase == ipv6tp_pkg::PH_TAIL_COLON);
      end

      if (go) begin
        if (parse_phase_next == ipv6tp_pkg::PH_HEAD_COLON) begin
          if (s_tdata == ipv6tp_pkg::CH_COLON) begin
            parse_phase_next = ipv6tp_pkg::PH_TAIL;
            skip = 1'b1;
          end else begin
            parse_phase_next = ipv6tp_pkg::PH_HEAD;
          end
        end else if (parse_phase_next == ipv6tp_pkg::PH_TAIL_COLON) begin
          if (s_tdata == ipv6tp_pkg::CH_COLON) begin
            // second compression ends the address
            emit    = 1'b1;
            emit_dc = 1'b1;
            parse_phase_next = ipv6tp_pkg::PH_DONE;
            skip = 1'b1;
          end else begin
            parse_phase_next = ipv6tp_pkg::PH_TAIL;
          end
        end

        if (!skip) begin
          in_tail = (parse_phase_next == ipv6tp_pkg::PH_TAIL);
          if (!hv[4]) begin
            group_accum_next = {group_accum_next[11:0], hv[3:0]};
            digit_seen_next  = 1'b1;
          end else begin
            if (digit_seen_next) begin
              if (in_tail) begin
                // tail list stays right-aligned: shift up, insert at the last group
                if (!tail_count_next[ipv6tp_pkg::COUNT_W-1]) begin
                  for (int i = 0; i < ipv6tp_pkg::GROUPS - 1; i++) begin
                    tail_groups_next[i] = tail_groups_next[i+1];
                  end
                  tail_groups_next[ipv6tp_pkg::GROUPS-1] = group_accum_next;
                  tail_count_next = tail_count_next + ipv6tp_pkg::count_t'(1);
                end else begin
                  overflow_seen_next = 1'b1;
                end
              end else begin
                if (!head_count_next[ipv6tp_pkg::COUNT_W-1]) begin
                  for (int i = 0; i < ipv6tp_pkg::GROUPS; i++) begin
                    if (head_count_next[ipv6tp_pkg::GROUP_IDX_W-1:0] ==
                        ipv6tp_pkg::GROUP_IDX_W'(i)) begin
                      head_groups_next[i] = group_accum_next;
                    end
                  end
                  head_count_next = head_count_next + ipv6tp_pkg::count_t'(1);
                end else begin
                  overflow_seen_next = 1'b1;
                end
              end
              group_accum_next = '0;
              digit_seen_next  = 1'b0;
            end
            if (s_tdata == ipv6tp_pkg::CH_COLON) begin
              parse_phase_next = in_tail ? ipv6tp_pkg::PH_TAIL_COLON
                                         : ipv6tp_pkg::PH_HEAD_COLON;
            end else begin
              emit    = 1'b1;
              emit_dc = in_tail;
              parse_phase_next = ipv6tp_pkg::PH_DONE;
            end
          end
        end
      end
    end
  end

  // Merge the lists: tail groups cover the last tail_count positions.
  always_comb begin
    for (int j = 0; j < ipv6tp_pkg::GROUPS; j++) begin
      if ((5'(tail_count_next) + 5'(j)) >= 5'(ipv6tp_pkg::GROUPS)) begin
        addr_next[127 - 16*j -: 16] = tail_groups_next[j];
      end else begin
        addr_next[127 - 16*j -: 16] = head_groups_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    head_groups <= head_groups_next;
    tail_groups <= tail_groups_next;
    if (rst) begin
      head_count    <= '0;
      tail_count    <= '0;
      group_accum   <= '0;
      digit_seen    <= 1'b0;
      parse_phase   <= ipv6tp_pkg::PH_IDLE;
      overflow_seen <= 1'b0;
    end else begin
      head_count    <= head_count_next;
      tail_count    <= tail_count_next;
      group_accum   <= group_accum_next;
      digit_seen    <= digit_seen_next;
      parse_phase   <= parse_phase_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_data <= {s_tdata, addr_next[63:0], addr_next[127:64]};
      out_user <= {overflow_seen_next, emit_dc};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  `ASSERT_NEVER(a_no_overwrite, s_tvalid && s_tready && m_tvalid && !m_tready, "request taken over a stalled result")
  `ASSERT_PROP(a_emit_shows, in_fire && emit |=> m_tvalid, "emitted result not presented")
  `ASSERT_PROP(a_idle_no_digits, (parse_phase == ipv6tp_pkg::PH_DONE || parse_phase == ipv6tp_pkg::PH_IDLE) |-> (!digit_seen && group_accum == '0), "pending digits outside a parse")
  `ASSERT_NEVER(a_count_range, head_count > 4'd8 || tail_count > 4'd8, "group count beyond eight")

endmodule

[bench/ipv6_text_address_parser_test.sv]
module ipv6_text_address_parser_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  stop_char;
    logic        had_dc;
    logic        too_many;
  } addr_result_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         first;
    logic         typed;
    addr_result_t want;
  } text_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;

  ipv6_text_address_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Parser state mirrored by the bench
  ipv6tp_pkg::group_t head_grp [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::group_t tail_grp [ipv6tp_pkg::GROUPS];
  ipv6tp_pkg::count_t head_n;
  ipv6tp_pkg::count_t tail_n;
  ipv6tp_pkg::group_t grp_accum;
  logic        have_digit;
  logic [2:0]  phase_q;
  logic        overflow_q;

  addr_result_t expected_addrs [$];
  text_row_t    directed_rows [$];
  addr_result_t got_addr;
  addr_result_t want_addr;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           parsed_chars = 0;
  bit           sender_no_idle = 1'b0;
  bit           ready_no_idle = 1'b0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return 16;
  endfunction

  function automatic void clear_parse_state();
    for (int i = 0; i < ipv6tp_pkg::GROUPS; i++) begin
      head_grp[i] = '0;
      tail_grp[i] = '0;
    end
    head_n = '0;
    tail_n = '0;
    grp_accum = '0;
    have_digit = 1'b0;
    overflow_q = 1'b0;
  endfunction

  // Lay the tail list right-aligned over the head list and finish the text.
  function automatic addr_result_t assemble_address(input logic [7:0] stop, input logic dc);
    ipv6tp_pkg::group_t g [ipv6tp_pkg::GROUPS];
    addr_result_t       r;
    for (int i = 0; i < ipv6tp_pkg::GROUPS; i++) g[i] = head_grp[i];
    for (int i = 0; i < int'(tail_n); i++)
      g[ipv6tp_pkg::GROUPS - int'(tail_n) + i] = tail_grp[i];
    r.addr_high = {g[0], g[1], g[2], g[3]};
    r.addr_low  = {g[4], g[5], g[6], g[7]};
    r.stop_char = stop;
    r.had_dc    = dc;
    r.too_many  = overflow_q;
    phase_q = ipv6tp_pkg::PH_DONE;
    return r;
  endfunction

  function automatic bit parse_text_char(input logic [7:0] ch, input logic first,
                                         output addr_result_t res);
    bit in_tail;
    int v;
    res = '0;
    if (first) begin
      clear_parse_state();
      phase_q = ipv6tp_pkg::PH_HEAD;
      if (ch == ipv6tp_pkg::CH_LBRACK) return 1'b0;
    end else if (!(phase_q inside {ipv6tp_pkg::PH_HEAD, ipv6tp_pkg::PH_HEAD_COLON,
                                   ipv6tp_pkg::PH_TAIL, ipv6tp_pkg::PH_TAIL_COLON})) begin
      return 1'b0;
    end
    if (phase_q == ipv6tp_pkg::PH_HEAD_COLON) begin
      if (ch == ipv6tp_pkg::CH_COLON) begin
        phase_q = ipv6tp_pkg::PH_TAIL;
        return 1'b0;
      end
      phase_q = ipv6tp_pkg::PH_HEAD;
    end else if (phase_q == ipv6tp_pkg::PH_TAIL_COLON) begin
      // second compression ends the address on its second colon
      if (ch == ipv6tp_pkg::CH_COLON) begin
        res = assemble_address(ch, 1'b1);
        return 1'b1;
      end
      phase_q = ipv6tp_pkg::PH_TAIL;
    end
    in_tail = (phase_q == ipv6tp_pkg::PH_TAIL);
    v = hex_value(ch);
    if (v < 16) begin
      grp_accum = {grp_accum[11:0], v[3:0]};
      have_digit = 1'b1;
      return 1'b0;
    end
    if (have_digit) begin
      if (in_tail) begin
        if (int'(tail_n) < ipv6tp_pkg::GROUPS) begin
          tail_grp[tail_n[2:0]] = grp_accum;
          tail_n++;
        end else begin
          overflow_q = 1'b1;
        end
      end else begin
        if (int'(head_n) < ipv6tp_pkg::GROUPS) begin
          head_grp[head_n[2:0]] = grp_accum;
          head_n++;
        end else begin
          overflow_q = 1'b1;
        end
      end
      grp_accum = '0;
      have_digit = 1'b0;
    end
    if (ch == ipv6tp_pkg::CH_COLON) begin
      phase_q = in_tail ? ipv6tp_pkg::PH_TAIL_COLON : ipv6tp_pkg::PH_HEAD_COLON;
      return 1'b0;
    end
    res = assemble_address(ch, in_tail);
    return 1'b1;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic add_row(input logic [7:0] ch, input logic first);
    directed_rows.push_back('{ch: ch, first: first, typed: 1'b0, want: '0});
  endtask

  task automatic add_typed(input logic [7:0] ch, input logic first, input addr_result_t want);
    directed_rows.push_back('{ch: ch, first: first, typed: 1'b1, want: want});
  endtask

  // Offer one character; predict at the edge where it is taken.
  task automatic send_char(input logic [7:0] ch, input logic first, input logic typed,
                           input addr_result_t want);
    int           gap;
    addr_result_t pred;
    gap = sender_no_idle ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 59) == 0) sender_no_idle = !sender_no_idle;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    if (first || (phase_q inside {ipv6tp_pkg::PH_HEAD, ipv6tp_pkg::PH_HEAD_COLON,
                                  ipv6tp_pkg::PH_TAIL, ipv6tp_pkg::PH_TAIL_COLON}))
      parsed_chars++;
    if (parse_text_char(ch, first, pred)) begin
      expected_addrs.push_back(typed ? want : pred);
    end
  endtask

  function automatic logic [7:0] random_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 16) return 8'(8'h61 + k - 10);
    return 8'(8'h41 + k - 16);
  endfunction

  function automatic logic [7:0] random_stop_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: return ipv6tp_pkg::CH_NUL;
      1: return CH_RBRACK;
      2: return 8'hFF;
      default: begin
        do c = 8'($urandom); while (hex_value(c) < 16 || c == ipv6tp_pkg::CH_COLON);
        return c;
      end
    endcase
  endfunction

  task automatic append_groups(ref logic [7:0] text [$], input int n);
    int len;
    for (int i = 0; i < n; i++) begin
      if (i > 0) text.push_back(ipv6tp_pkg::CH_COLON);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (int j = 0; j < len; j++) text.push_back(random_hex_char());
    end
  endtask

  // Mostly well-formed address text with random groups; a few are broken.
  task automatic send_address();
    logic [7:0] text [$];
    bit         squeeze;
    int         n;
    if ($urandom_range(0, 3) == 0) text.push_back(ipv6tp_pkg::CH_LBRACK);
    if ($urandom_range(0, 9) == 0) text.push_back(ipv6tp_pkg::CH_COLON);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
    append_groups(text, n);
    squeeze = ($urandom_range(0, 2) != 0);
    if (squeeze) begin
      text.push_back(ipv6tp_pkg::CH_COLON);
      text.push_back(ipv6tp_pkg::CH_COLON);
      if ($urandom_range(0, 7) == 0) text.push_back(ipv6tp_pkg::CH_COLON);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
      append_groups(text, n);
    end
    if (squeeze && $urandom_range(0, 4) == 0) begin
      text.push_back(ipv6tp_pkg::CH_COLON);
      text.push_back(ipv6tp_pkg::CH_COLON);
    end else begin
      text.push_back(random_stop_char());
    end
    if ($urandom_range(0, 6) == 0)
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
    // drop the stop so the next text restarts mid-parse
    if ($urandom_range(0, 9) == 0 && text.size() > 1) void'(text.pop_back());
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == 0, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_addr.addr_high = m_tdata[63:0];
      got_addr.addr_low  = m_tdata[127:64];
      got_addr.stop_char = m_tdata[135:128];
      got_addr.had_dc    = m_tuser[0];
      got_addr.too_many  = m_tuser[1];
      if (expected_addrs.size() == 0) begin
        report_failure($sformatf("unexpected address hi=%h lo=%h stop=%h dc=%b ovf=%b",
                       got_addr.addr_high, got_addr.addr_low, got_addr.stop_char,
                       got_addr.had_dc, got_addr.too_many));
      end else begin
        want_addr = expected_addrs.pop_front();
        if (got_addr.addr_high !== want_addr.addr_high ||
            got_addr.addr_low  !== want_addr.addr_low  ||
            got_addr.stop_char !== want_addr.stop_char ||
            got_addr.had_dc    !== want_addr.had_dc    ||
            got_addr.too_many  !== want_addr.too_many) begin
          report_failure($sformatf(
            "address mismatch: expected hi=%h lo=%h stop=%h dc=%b ovf=%b, got hi=%h lo=%h stop=%h dc=%b ovf=%b",
            want_addr.addr_high, want_addr.addr_low, want_addr.stop_char, want_addr.had_dc,
            want_addr.too_many, got_addr.addr_high, got_addr.addr_low, got_addr.stop_char,
            got_addr.had_dc, got_addr.too_many));
        end
      end
    end
  end

  // Result side: random stalls, two long hold-offs to back up the input.
  initial begin : ready_driver
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken == 5 || taken == 40) begin
        gap = LONG_HOLD;
      end else begin
        gap = ready_no_idle ? 0 : $urandom_range(0, 8);
      end
      if ($urandom_range(0, 59) == 0) ready_no_idle = !ready_no_idle;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : text_driver
    int addr_idx;
    clear_parse_state();
    phase_q = ipv6tp_pkg::PH_IDLE;

    // bracket, leading compression, closing bracket as stop
    add_row(ipv6tp_pkg::CH_LBRACK, 1'b1);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    add_row("f", 1'b0);
    add_typed(CH_RBRACK, 1'b0, addr_result_t'{64'h0, 64'hF, CH_RBRACK, 1'b1, 1'b0});
    // ignored while done
    add_row("A", 1'b0);
    add_typed(ipv6tp_pkg::CH_NUL, 1'b1,
              addr_result_t'{64'h0, 64'h0, ipv6tp_pkg::CH_NUL, 1'b0, 1'b0});
    add_typed(8'hFF, 1'b1, addr_result_t'{64'h0, 64'h0, 8'hFF, 1'b0, 1'b0});
    // restart, then triple colon and a second compression
    add_row("1", 1'b1);
    add_row("2", 1'b1);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    add_row(ipv6tp_pkg::CH_COLON, 1'b0);
    // nine head groups: the last one is dropped
    for (int k = 1; k <= 9; k++) begin
      if (k > 1) add_row(ipv6tp_pkg::CH_COLON, 1'b0);
      add_row(8'(8'h30 + k), k == 1);
    end
    add_row("g", 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].first, directed_rows[i].typed,
                directed_rows[i].want);

    addr_idx = 0;
    parsed_chars = 0;
    while (parsed_chars < 650) begin
      if (addr_idx % 25 == 10) begin
        // drain: hold off until every address is back
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_addrs.size() != 0);
      end
      send_address();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          send_char(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
      end
      addr_idx++;
    end

    s_tvalid <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
